// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/blac_pkg.sv =====
// Types and constants shared by the list engine modules.
package blac_pkg;

   localparam int WORD_W        = 32;
   localparam int POS_W         = 6;
   localparam int COUNT_W       = 7;
   localparam int OPCODE_W      = 3;
   localparam int STATUS_W      = 2;
   localparam int DEPTH_DEFAULT = 64;
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_SEARCH = 3'd3,
      OP_READ   = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   // Broadcast control from the sequencer to every cell of the chain
   typedef struct packed {
      logic                append;
      logic                insert;
      logic                remove;
      logic                lane_load;
      logic                lane_shift;
      logic                is_search;
      logic [POS_W-1:0]    pos;
      logic [COUNT_W-1:0]  count;
      logic [WORD_W-1:0]   word;
   } chain_ctrl_type;

endpackage

// ===== hw/rtl/bounded_array_list_engine.sv =====
// Bounded array list engine: top level with sequencer, result register and cell chain.
//
// Usage: one request transaction (req_opcode, req_position, req_word_in) gives
// exactly one response transaction (rsp_status, rsp_match_index, rsp_word_out,
// rsp_entry_count). Both channels use valid/stall; a transaction moves on a
// clock edge with valid high and stall low. csr_write_enable/csr_write_data set
// the capacity register (entries allowed in use, saturated to DEPTH).
// Append, insert, delete, errors and unused opcodes answer in the cycle after
// acceptance, and the next request may follow in the next cycle if the response is not stalled.
// Search and read unload a scan lane from the cell chain one entry per cycle:
// a search or read answers once its hit reaches the lane head, a search miss
// once the last entry is inspected; the request side is stalled for that scan.
// Insert and delete shift the affected entries of the chain all at once.
// Reset (synchronous, active high) empties the list and sets capacity to 64;
// entry contents are not cleared and are never read before written.
// When the response side stalls, the result is held in the output register;
// one more request is taken only if it frees the register in the same cycle.
`include "assert_macros.svh"

module bounded_array_list_engine
   import blac_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [WORD_W-1:0]   req_word_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [POS_W-1:0]           rsp_match_index,
   output logic signed [WORD_W-1:0]   rsp_word_out,
   output logic [COUNT_W-1:0]         rsp_entry_count,
   input  logic                       csr_write_enable,
   input  logic [COUNT_W-1:0]         csr_write_data
);

   localparam int COUNT_MAX = (2 ** COUNT_W) - 1;
   localparam int DEPTH_SAT = (DEPTH > COUNT_MAX) ? COUNT_MAX : DEPTH;
   localparam logic [COUNT_W-1:0] DEPTH_LIM = COUNT_W'(DEPTH_SAT);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0]      capacity_ff, capacity_in;
   logic [COUNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                    scan_search_ff, scan_search_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]        rsp_match_ff, rsp_match_in;
   logic [WORD_W-1:0]       rsp_word_ff, rsp_word_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   chain_ctrl_type          ctrl;
   logic                    head_flag;
   logic [WORD_W-1:0]       head_data;
   logic [COUNT_W-1:0]      limit;
   logic                    list_full;
   logic                    pos_in_list;
   logic                    out_free;
   logic                    req_accept;

   // Effective limit and request checks
   assign limit       = (capacity_ff > DEPTH_LIM) ? DEPTH_LIM : capacity_ff;
   assign list_full   = (count_ff >= limit);
   assign pos_in_list = ({1'b0, req_position} < count_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = !((state_ff == ST_IDLE) && out_free);
   assign req_accept  = req_valid && !req_stall;

   // Sequencer: decode requests, drive the chain, build the result
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      capacity_in    = csr_write_enable ? csr_write_data : capacity_ff;
      scan_idx_in    = scan_idx_ff;
      scan_search_in = scan_search_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_match_in   = rsp_match_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_count_in   = rsp_count_ff;

      ctrl       = '0;
      ctrl.pos   = req_position;
      ctrl.count = count_ff;
      ctrl.word  = req_word_in;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_match_in  = '0;
               rsp_word_in   = '0;
               unique case (opcode_type'(req_opcode))
                  OP_APPEND: begin
                     if (!list_full) begin
                        ctrl.append = 1'b1;
                        count_in    = count_ff + 1'b1;
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  OP_INSERT: begin
                     priority if (list_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (pos_in_list) begin
                        ctrl.insert = 1'b1;
                        count_in    = count_ff + 1'b1;
                     end else begin
                        rsp_status_in = STATUS_RANGE;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_in_list) begin
                        ctrl.remove = 1'b1;
                        count_in    = count_ff - 1'b1;
                     end else begin
                        rsp_status_in = STATUS_RANGE;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_NOTFOUND;
                     end else begin
                        ctrl.lane_load = 1'b1;
                        ctrl.is_search = 1'b1;
                        rsp_valid_in   = 1'b0;
                        scan_search_in = 1'b1;
                        scan_idx_in    = '0;
                        state_in       = ST_SCAN;
                     end
                  end
                  OP_READ: begin
                     if (pos_in_list) begin
                        ctrl.lane_load = 1'b1;
                        rsp_valid_in   = 1'b0;
                        scan_search_in = 1'b0;
                        scan_idx_in    = '0;
                        state_in       = ST_SCAN;
                     end else begin
                        rsp_status_in = STATUS_RANGE;
                     end
                  end
                  default: begin
                     // unused opcodes leave the list alone
                     rsp_status_in = STATUS_OK;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         ST_SCAN: begin
            // Inspect the lane head; it holds entry scan_idx_ff
            if (out_free) begin
               priority if (head_flag) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_match_in  = scan_search_ff ? scan_idx_ff[POS_W-1:0] : '0;
                  rsp_word_in   = scan_search_ff ? '0 : head_data;
                  rsp_count_in  = count_ff;
                  state_in      = ST_IDLE;
               end else if (scan_idx_ff + 1'b1 >= count_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOTFOUND;
                  rsp_match_in  = '0;
                  rsp_word_in   = '0;
                  rsp_count_in  = count_ff;
                  state_in      = ST_IDLE;
               end else begin
                  ctrl.lane_shift = 1'b1;
                  scan_idx_in     = scan_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         capacity_ff    <= CAPACITY_RESET;
         scan_idx_ff    <= '0;
         scan_search_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         capacity_ff    <= capacity_in;
         scan_idx_ff    <= scan_idx_in;
         scan_search_ff <= scan_search_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
   end

   blac_chain #(.DEPTH(DEPTH)) u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .head_flag (head_flag),
      .head_data (head_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = rsp_match_ff;
   assign rsp_word_out    = $signed(rsp_word_ff);
   assign rsp_entry_count = rsp_count_ff;

   // Checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_LIM, "count beyond depth")
   `ASSERT_NEXT(a_count_hold, clock, reset, !req_accept, $stable(count_ff), "count changed")
   `ASSERT_IMPLY(a_scan_stalls, clock, reset, state_ff == ST_SCAN, req_stall, "taken during scan")
   `ASSERT_IMPLY(a_scan_range, clock, reset, state_ff == ST_SCAN, scan_idx_ff < count_ff, "overrun")

endmodule

// ===== hw/rtl/blac_cell.sv =====
// One list cell: holds one entry and one stage of the scan lane.
module blac_cell
   import blac_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  chain_ctrl_type      ctrl,
   input  logic [WORD_W-1:0]   left_entry,
   input  logic [WORD_W-1:0]   right_entry,
   input  logic                right_lane_flag,
   input  logic [WORD_W-1:0]   right_lane_data,
   output logic [WORD_W-1:0]   entry,
   output logic                lane_flag,
   output logic [WORD_W-1:0]   lane_data
);

   localparam logic [31:0] IDX_W = 32'(INDEX);

   logic [WORD_W-1:0] entry_ff, entry_in;
   logic              lane_flag_ff, lane_flag_in;
   logic [WORD_W-1:0] lane_data_ff, lane_data_in;
   logic [31:0]       pos_w;
   logic [31:0]       cnt_w;

   assign pos_w = 32'(ctrl.pos);
   assign cnt_w = 32'(ctrl.count);

   // Entry update: append at the end, shift up on insert, shift down on delete
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.append) begin
         if (IDX_W == cnt_w) entry_in = ctrl.word;
      end else if (ctrl.insert) begin
         if (IDX_W == pos_w) entry_in = ctrl.word;
         else if (IDX_W > pos_w && IDX_W <= cnt_w) entry_in = left_entry;
      end else if (ctrl.remove) begin
         if (IDX_W >= pos_w && IDX_W + 32'd1 < cnt_w) entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   // Scan lane: load hit flag and entry, then shift toward cell zero
   always_comb begin
      lane_flag_in = lane_flag_ff;
      lane_data_in = lane_data_ff;
      priority if (ctrl.lane_load) begin
         lane_flag_in = ctrl.is_search ? (entry_ff == ctrl.word && IDX_W < cnt_w)
                                       : (IDX_W == pos_w);
         lane_data_in = entry_ff;
      end else if (ctrl.lane_shift) begin
         lane_flag_in = right_lane_flag;
         lane_data_in = right_lane_data;
      end else begin
         lane_flag_in = lane_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      lane_flag_ff <= lane_flag_in;
      lane_data_ff <= lane_data_in;
   end

   assign entry     = entry_ff;
   assign lane_flag = lane_flag_ff;
   assign lane_data = lane_data_ff;

endmodule

// ===== hw/rtl/blac_chain.sv =====
// Row of list cells wired to their neighbors; exposes the head of the scan lane.
module blac_chain
   import blac_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                clock,
   input  chain_ctrl_type      ctrl,
   output logic                head_flag,
   output logic [WORD_W-1:0]   head_data
);

   logic [WORD_W-1:0] entry_q   [DEPTH];
   logic              lane_flag [DEPTH];
   logic [WORD_W-1:0] lane_data [DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [WORD_W-1:0] left_e;
         logic [WORD_W-1:0] right_e;
         logic              right_f;
         logic [WORD_W-1:0] right_d;

         // Ends see constant neighbors; their entry inputs are never selected
         if (gi == 0) begin : g_first
            assign left_e = '0;
         end else begin : g_mid_l
            assign left_e = entry_q[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_e = '0;
            assign right_f = 1'b0;
            assign right_d = '0;
         end else begin : g_mid_r
            assign right_e = entry_q[gi+1];
            assign right_f = lane_flag[gi+1];
            assign right_d = lane_data[gi+1];
         end

         blac_cell #(.INDEX(gi)) u_cell (
            .clock           (clock),
            .ctrl            (ctrl),
            .left_entry      (left_e),
            .right_entry     (right_e),
            .right_lane_flag (right_f),
            .right_lane_data (right_d),
            .entry           (entry_q[gi]),
            .lane_flag       (lane_flag[gi]),
            .lane_data       (lane_data[gi])
         );
      end
   endgenerate

   assign head_flag = lane_flag[0];
   assign head_data = lane_data[0];

endmodule

// ===== test/tb_bounded_array_list_engine.sv =====
// Self-checking testbench for the bounded array list engine.
`timescale 1ns / 100ps

module tb_bounded_array_list_engine;
   import blac_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;
   localparam logic signed [WORD_W-1:0] WORD_MIN      = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_ALL_ONES = -32'sd1;
   localparam int IDLE_PERCENT = 38;

   // One response as seen on the result channel
   typedef struct packed {
      status_type                 status;
      logic [POS_W-1:0]           match_index;
      logic signed [WORD_W-1:0]   word_out;
      logic [COUNT_W-1:0]         entry_count;
   } list_outcome_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [OPCODE_W-1:0]        req_opcode = '0;
   logic [POS_W-1:0]           req_position = '0;
   logic signed [WORD_W-1:0]   req_word_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [POS_W-1:0]           rsp_match_index;
   logic signed [WORD_W-1:0]   rsp_word_out;
   logic [COUNT_W-1:0]         rsp_entry_count;
   logic                       csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]         csr_write_data = '0;

   // Predictor state: stored words, count and capacity register
   logic signed [WORD_W-1:0]   list_words [LIST_DEPTH];
   int                         list_count = 0;
   int                         capacity = CAPACITY_RESET;
   list_outcome_type           list_outcomes [$];
   int                         error_count = 0;
   bit                         idle_enable = 1'b1;

   bounded_array_list_engine #(
      .DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_position     (req_position),
      .req_word_in      (req_word_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_match_index  (rsp_match_index),
      .rsp_word_out     (rsp_word_out),
      .rsp_entry_count  (rsp_entry_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop if the run hangs
   initial begin
      #5_000_000;
      $display("bounded_array_list_engine test failed");
      $finish;
   end

   // Applies one operation to the predicted list and returns its response
   function automatic list_outcome_type apply_list_op(input logic [OPCODE_W-1:0] op,
                                                      input int pos,
                                                      input logic signed [WORD_W-1:0] word);
      list_outcome_type o;
      int               limit;
      int               i;
      bit               hit;
      o.status      = STATUS_OK;
      o.match_index = '0;
      o.word_out    = '0;
      limit = (capacity > LIST_DEPTH) ? LIST_DEPTH : capacity;
      hit   = 1'b0;
      case (op)
         OP_APPEND: begin
            if (list_count < limit) begin
               list_words[list_count] = word;
               list_count++;
            end else begin
               o.status = STATUS_FULL;
            end
         end
         OP_INSERT: begin
            // full takes priority over a bad index
            if (list_count >= limit) begin
               o.status = STATUS_FULL;
            end else if (pos < list_count) begin
               for (i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = word;
               list_count++;
            end else begin
               o.status = STATUS_RANGE;
            end
         end
         OP_DELETE: begin
            if (pos < list_count) begin
               for (i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end else begin
               o.status = STATUS_RANGE;
            end
         end
         OP_SEARCH: begin
            o.status = STATUS_NOTFOUND;
            for (i = 0; i < list_count && !hit; i++) begin
               if (list_words[i] == word) begin
                  hit           = 1'b1;
                  o.status      = STATUS_OK;
                  o.match_index = POS_W'(i);
               end
            end
         end
         OP_READ: begin
            if (pos < list_count) o.word_out = list_words[pos];
            else o.status = STATUS_RANGE;
         end
         default: begin
            // unused opcodes leave everything alone
         end
      endcase
      o.entry_count = COUNT_W'(list_count);
      return o;
   endfunction

   // Sends one request transaction and records its predicted response
   task automatic issue_list_op(input logic [OPCODE_W-1:0] op, input int pos,
                                input logic signed [WORD_W-1:0] word);
      while (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_position <= POS_W'(pos);
      req_word_in  <= word;
      do @(posedge clock); while (req_stall);
      list_outcomes.push_back(apply_list_op(op, pos & 6'h3F, word));
   endtask

   // Stops sending and waits until every response has come back
   task automatic wait_list_idle();
      req_valid <= 1'b0;
      while (list_outcomes.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      wait_list_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= COUNT_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity = value & 7'h7F;
   endtask

   // Random operations; count drifts toward a target redrawn now and then
   task automatic run_random_ops(input int n_ops, input bit small_words);
      int                        k;
      int                        r;
      int                        target;
      int                        pos;
      int                        w_app;
      int                        w_ins;
      logic [OPCODE_W-1:0]       op;
      logic signed [WORD_W-1:0]  word;
      target = 0;
      for (k = 0; k < n_ops; k++) begin
         if (k % 40 == 0) target = $urandom_range(0, LIST_DEPTH);
         if (list_count < target) begin
            w_app = 30;
            w_ins = 52;
         end else begin
            w_app = 12;
            w_ins = 22;
         end
         r = $urandom_range(0, 99);
         if (r < w_app) op = OP_APPEND;
         else if (r < w_ins) op = OP_INSERT;
         else if (r < 62) op = OP_DELETE;
         else if (r < 80) op = OP_SEARCH;
         else if (r < 97) op = OP_READ;
         else op = OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));

         // mostly valid indexes, some at the boundary, some anywhere
         r = $urandom_range(0, 99);
         if (list_count > 0 && r < 70) pos = $urandom_range(0, list_count - 1);
         else if (r < 80) pos = list_count;
         else pos = $urandom_range(0, 63);

         r = $urandom_range(0, 99);
         if (small_words) begin
            word = int'($urandom_range(0, 7)) - 4;
         end else if (r < 10) begin
            case ($urandom_range(0, 3))
               0: word = WORD_MIN;
               1: word = WORD_MAX;
               2: word = WORD_ALL_ONES;
               default: word = '0;
            endcase
         end else begin
            word = $urandom();
         end
         // searches mostly look for a word that is stored
         if (op == OP_SEARCH && list_count > 0 && $urandom_range(0, 99) < 60)
            word = list_words[$urandom_range(0, list_count - 1)];
         issue_list_op(op, pos, word);
      end
   endtask

   // Edge cases at reset capacity: empty list, extremes, boundaries, unused opcodes
   task automatic test_directed_ops();
      logic [OPCODE_W-1:0] op;
      issue_list_op(OP_READ, 0, '0);
      issue_list_op(OP_DELETE, 0, '0);
      issue_list_op(OP_SEARCH, 0, '0);
      issue_list_op(OP_INSERT, 0, 32'sd5);
      issue_list_op(OP_APPEND, 63, WORD_MIN);
      issue_list_op(OP_APPEND, 0, WORD_MAX);
      issue_list_op(OP_APPEND, 0, WORD_ALL_ONES);
      issue_list_op(OP_APPEND, 0, '0);
      issue_list_op(OP_INSERT, 0, 32'sh1234_5678);
      issue_list_op(OP_INSERT, list_count - 1, 32'sh0F0F_F0F0);
      issue_list_op(OP_INSERT, list_count, 32'sd7);
      issue_list_op(OP_INSERT, 63, 32'sd7);
      // duplicate key: search must report the first one
      issue_list_op(OP_APPEND, 0, WORD_ALL_ONES);
      issue_list_op(OP_SEARCH, 0, WORD_ALL_ONES);
      issue_list_op(OP_SEARCH, 0, WORD_MIN);
      issue_list_op(OP_SEARCH, 0, 32'sh5555_AAAA);
      issue_list_op(OP_READ, 0, '0);
      issue_list_op(OP_READ, list_count - 1, '0);
      issue_list_op(OP_READ, 63, '0);
      issue_list_op(OP_DELETE, list_count - 1, '0);
      issue_list_op(OP_DELETE, 0, '0);
      issue_list_op(OP_DELETE, 63, '0);
      for (op = OP_UNUSED_FIRST; op >= OP_UNUSED_FIRST; op++)
         issue_list_op(op, 63, WORD_ALL_ONES);
   endtask

   // Capacity register: below count, zero, one-ish, saturation and a full list
   task automatic test_capacity_limits();
      while (list_count < 6) issue_list_op(OP_APPEND, 0, $urandom());
      write_capacity(2);
      issue_list_op(OP_APPEND, 0, 32'sd11);
      issue_list_op(OP_INSERT, 63, 32'sd12);
      issue_list_op(OP_INSERT, 0, 32'sd12);
      while (list_count > 1) issue_list_op(OP_DELETE, 0, '0);
      issue_list_op(OP_APPEND, 0, 32'sd13);
      issue_list_op(OP_INSERT, 0, 32'sd14);
      issue_list_op(OP_READ, 1, '0);

      // zero capacity is always full
      write_capacity(0);
      issue_list_op(OP_APPEND, 0, 32'sd15);
      issue_list_op(OP_INSERT, 0, 32'sd16);
      issue_list_op(OP_READ, 0, '0);
      issue_list_op(OP_DELETE, 0, '0);
      issue_list_op(OP_SEARCH, 0, 32'sd13);

      // capacity above the depth saturates; fill every entry
      write_capacity(127);
      while (list_count < LIST_DEPTH) issue_list_op(OP_APPEND, 0, $urandom());
      issue_list_op(OP_APPEND, 0, 32'sd17);
      issue_list_op(OP_INSERT, 0, 32'sd18);
      issue_list_op(OP_SEARCH, 0, list_words[LIST_DEPTH-1]);
      issue_list_op(OP_SEARCH, 0, $urandom());
      issue_list_op(OP_READ, 63, '0);
      issue_list_op(OP_DELETE, 63, '0);
      issue_list_op(OP_INSERT, 62, WORD_MIN);
      issue_list_op(OP_READ, 63, '0);
      issue_list_op(OP_DELETE, 0, '0);
      write_capacity(1);
      issue_list_op(OP_APPEND, 0, 32'sd19);
      while (list_count > 0) issue_list_op(OP_DELETE, $urandom_range(0, list_count - 1), '0);
      issue_list_op(OP_APPEND, 0, 32'sd20);
      issue_list_op(OP_APPEND, 0, 32'sd21);
      write_capacity(LIST_DEPTH);
   endtask

   // Random traffic across several capacity settings
   task automatic test_random_ops();
      run_random_ops(150, 1'b0);
      // back-to-back stretch, neither side idles
      idle_enable = 1'b0;
      run_random_ops(100, 1'b1);
      idle_enable = 1'b1;
      write_capacity($urandom_range(1, 16));
      run_random_ops(80, 1'b0);
      // sender holds off until every response is back
      wait_list_idle();
      run_random_ops(80, 1'b1);
      write_capacity(127);
      run_random_ops(110, 1'b0);
   endtask

   // Response checker and random stall on the result side
   always @(posedge clock) begin : rsp_check
      list_outcome_type want;
      list_outcome_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status      = status_type'(rsp_status);
         got.match_index = rsp_match_index;
         got.word_out    = rsp_word_out;
         got.entry_count = rsp_entry_count;
         if (list_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: response with nothing outstanding, actual status %0d",
                     $time, got.status,
                     " index %0d word %0d count %0d",
                     got.match_index, got.word_out, got.entry_count);
         end else begin
            want = list_outcomes.pop_front();
            if (got !== want) begin
               error_count++;
               $display("%0t: expected status %0d index %0d word %0d count %0d,",
                        $time, want.status, want.match_index, want.word_out,
                        want.entry_count,
                        " actual status %0d index %0d word %0d count %0d",
                        got.status, got.match_index, got.word_out, got.entry_count);
            end
         end
      end
      rsp_stall <= !reset && idle_enable && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_capacity_limits();
      test_random_ops();
      wait_list_idle();
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("bounded_array_list_engine test passed");
      end else begin
         $display("bounded_array_list_engine test failed");
      end
      $finish;
   end

endmodule
